FILE: sv/ole_pkg.sv
// Ordered list engine package: sizes, operation and status codes,
// cell command struct and sequencer state type. No dependencies.
package ole_pkg;

    localparam int DEPTH   = 64;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KIND_W  = 4;
    localparam int STAT_W  = 3;
    localparam int CAP_W   = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;
    localparam logic [CAP_W-1:0]   CAP_RESET    = CAP_W'(DEPTH);

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_BACK  = 4'd0,
        K_POP_BACK   = 4'd1,
        K_PUSH_FRONT = 4'd2,
        K_POP_FRONT  = 4'd3,
        K_INSERT     = 4'd4,
        K_DELETE     = 4'd5,
        K_DELETE_VAL = 4'd6,
        K_FIND       = 4'd7,
        K_GET        = 4'd8,
        K_SET        = 4'd9,
        K_FIRST      = 4'd10,
        K_LAST       = 4'd11
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD  = 3'd0,
        OP_CMP   = 3'd1,
        OP_UP    = 3'd2,
        OP_DOWN  = 3'd3,
        OP_WRITE = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [IDX_W-1:0]   idx;
        logic               rd_en;
        logic [IDX_W-1:0]   rd_idx;
        logic [VALUE_W-1:0] data;
        logic [CNT_W-1:0]   cnt;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_APPLY = 3'b100
    } seq_state_t;

endpackage

FILE: sv/ole_cell.sv
// One list cell: holds an entry, shifts to/from its neighbours,
// flags a key match and drives its entry onto the read bus when selected. Uses ole_pkg.
module ole_cell
    import ole_pkg::*;
(
    input  logic               clk,
    input  logic [IDX_W-1:0]   cell_index,
    input  cell_cmd_t          cmd,
    input  logic [VALUE_W-1:0] below_data,
    input  logic [VALUE_W-1:0] above_data,
    output logic [VALUE_W-1:0] data,
    output logic               match,
    output logic [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;
    logic               match_reg;
    logic               match_next;

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        case (cmd.op)
            OP_UP:
            begin
                if (cell_index > cmd.idx)
                begin
                    entry_next = below_data;
                end
                else if (cell_index == cmd.idx)
                begin
                    entry_next = cmd.data;
                end
            end
            OP_DOWN:
            begin
                if (cell_index >= cmd.idx)
                begin
                    entry_next = above_data;
                end
            end
            OP_WRITE:
            begin
                if (cell_index == cmd.idx)
                begin
                    entry_next = cmd.data;
                end
            end
            OP_CMP:
            begin
                match_next = ({1'b0, cell_index} < cmd.cnt) && (entry_reg == cmd.data);
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign data    = entry_reg;
    assign match   = match_reg;
    assign rd_data = (cmd.rd_en && (cmd.rd_idx == cell_index)) ? entry_reg : '0;

endmodule

FILE: sv/ole_ctrl.sv
// Sequencer for the ordered list: takes an operation, runs the cell compare,
// decides the shift and result, and holds the result register. Uses ole_pkg.
module ole_ctrl
    import ole_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [KIND_W-1:0]  kind,
    input  logic [VALUE_W-1:0] value,
    input  logic [IDX_W-1:0]   position,
    input  logic [CNT_W-1:0]   eff_cap,
    input  logic [DEPTH-1:0]   match_vec,
    input  logic [VALUE_W-1:0] rd_bus,
    output cell_cmd_t          cmd,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [VALUE_W-1:0] read_value,
    output logic [IDX_W-1:0]   found_index,
    output logic [CNT_W-1:0]   entry_count,
    output logic [STAT_W-1:0]  status
);

    seq_state_t         state_reg, state_next;
    kind_t              kind_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               res_valid_reg;
    logic [VALUE_W-1:0] res_value_reg;
    logic [IDX_W-1:0]   res_fidx_reg;
    logic [CNT_W-1:0]   res_count_reg;
    status_t            res_status_reg;

    logic               full;
    logic               empty;
    logic [CNT_W-1:0]   pos_ext;
    logic [CNT_W-1:0]   count_dec;
    logic [IDX_W-1:0]   last_idx;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    cell_op_t           dec_op;
    logic [IDX_W-1:0]   dec_idx;
    logic               dec_rd_en;
    logic [IDX_W-1:0]   dec_rd_idx;
    logic [IDX_W-1:0]   dec_fidx;
    status_t            dec_status;
    logic               fire;

    assign full      = count_reg >= eff_cap;
    assign empty     = count_reg == '0;
    assign pos_ext   = {1'b0, pos_reg};
    assign count_dec = count_reg - CNT_W'(1);
    assign last_idx  = count_dec[IDX_W-1:0];
    assign fire      = (state_reg == S_APPLY) && (!res_valid_reg || !result_stall);

    // lowest matching cell
    always_comb
    begin
        hit     = |match_vec;
        hit_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        dec_op     = OP_HOLD;
        dec_idx    = '0;
        dec_rd_en  = 1'b0;
        dec_rd_idx = '0;
        dec_fidx   = '0;
        dec_status = ST_OK;
        count_next = count_reg;
        unique case (kind_reg) inside
            K_PUSH_BACK, K_PUSH_FRONT:
            begin
                if (full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_op     = OP_UP;
                    dec_idx    = (kind_reg == K_PUSH_BACK) ? count_reg[IDX_W-1:0] : '0;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            K_POP_BACK, K_POP_FRONT:
            begin
                if (empty)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_op     = OP_DOWN;
                    dec_idx    = (kind_reg == K_POP_BACK) ? last_idx : '0;
                    dec_rd_en  = 1'b1;
                    dec_rd_idx = dec_idx;
                    count_next = count_dec;
                end
            end
            K_INSERT:
            begin
                if (pos_ext > count_reg)
                begin
                    dec_status = ST_RANGE;
                end
                else if (full)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    dec_op     = OP_UP;
                    dec_idx    = pos_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            K_DELETE:
            begin
                if (empty)
                begin
                    dec_status = ST_EMPTY;
                end
                else if (pos_ext >= count_reg)
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_op     = OP_DOWN;
                    dec_idx    = pos_reg;
                    dec_rd_en  = 1'b1;
                    dec_rd_idx = pos_reg;
                    count_next = count_dec;
                end
            end
            K_DELETE_VAL:
            begin
                if (hit)
                begin
                    dec_op     = OP_DOWN;
                    dec_idx    = hit_idx;
                    dec_rd_en  = 1'b1;
                    dec_rd_idx = hit_idx;
                    count_next = count_dec;
                end
                else
                begin
                    dec_status = ST_NOTFOUND;
                end
            end
            K_FIND:
            begin
                if (hit)
                begin
                    dec_rd_en  = 1'b1;
                    dec_rd_idx = hit_idx;
                    dec_fidx   = hit_idx;
                end
                else
                begin
                    dec_status = ST_NOTFOUND;
                end
            end
            K_GET:
            begin
                if (pos_ext >= count_reg)
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_rd_en  = 1'b1;
                    dec_rd_idx = pos_reg;
                end
            end
            K_SET:
            begin
                if (pos_ext >= count_reg)
                begin
                    dec_status = ST_RANGE;
                end
                else
                begin
                    dec_op  = OP_WRITE;
                    dec_idx = pos_reg;
                end
            end
            K_FIRST, K_LAST:
            begin
                if (empty)
                begin
                    dec_status = ST_EMPTY;
                end
                else
                begin
                    dec_rd_en  = 1'b1;
                    dec_rd_idx = (kind_reg == K_LAST) ? last_idx : '0;
                end
            end
            default:
            begin
                dec_status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        cmd.op     = OP_HOLD;
        cmd.idx    = dec_idx;
        cmd.rd_en  = dec_rd_en;
        cmd.rd_idx = dec_rd_idx;
        cmd.data   = value_reg;
        cmd.cnt    = count_reg;
        if (state_reg == S_MATCH)
        begin
            cmd.op = OP_CMP;
        end
        else if (fire)
        begin
            cmd.op = dec_op;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && item_valid)
        begin
            kind_reg  <= kind_t'(kind);
            value_reg <= value;
            pos_reg   <= position;
        end
        if (fire)
        begin
            res_value_reg  <= dec_rd_en ? rd_bus : '0;
            res_fidx_reg   <= dec_fidx;
            res_count_reg  <= count_next;
            res_status_reg <= dec_status;
        end
    end

    assign item_stall   = state_reg != S_IDLE;
    assign result_valid = res_valid_reg;
    assign read_value   = res_value_reg;
    assign found_index  = res_fidx_reg;
    assign entry_count  = res_count_reg;
    assign status       = res_status_reg;

endmodule

FILE: sv/ordered_list_engine.sv
// Ordered list engine top level: APB capacity register, row of list cells
// and sequencer. Uses ole_pkg, ole_cell and ole_ctrl.
//
// Keeps an ordered list of up to 64 32-bit values in a row of cells that
// shift up or down in one step. One item is handled at a time: it is
// captured, the compare of all cells against the key is registered, then
// the shift is applied and the result register loaded, with the input
// held off until the result is presented. A waiting result holds off
// only the apply step. A push or in-range insert into a full list
// (count at or above capacity_limit, 0 counting as 1, above 64 as 64)
// gets status full. capacity_limit is written at APB offset 0, by the
// user only while the block is idle; the block does not enforce this.
module ordered_list_engine
    import ole_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [KIND_W-1:0]  kind,
    input  logic [VALUE_W-1:0] value,
    input  logic [IDX_W-1:0]   position,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [VALUE_W-1:0] read_value,
    output logic [IDX_W-1:0]   found_index,
    output logic [CNT_W-1:0]   entry_count,
    output logic [STAT_W-1:0]  status
);

    logic [CAP_W-1:0]   capacity_reg;
    logic [CNT_W-1:0]   eff_cap;
    cell_cmd_t          cmd;
    logic [VALUE_W-1:0] cell_data [DEPTH];
    logic [VALUE_W-1:0] cell_rd   [DEPTH];
    logic [DEPTH-1:0]   match_vec;
    logic [VALUE_W-1:0] rd_bus;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2] == REG_CAPACITY;
    assign prdata  = reg_sel ? PDATA_W'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (CNT_W'(capacity_reg) > CNT_W'(DEPTH))
        begin
            eff_cap = CNT_W'(DEPTH);
        end
        else
        begin
            eff_cap = CNT_W'(capacity_reg);
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_W-1:0] below;
        logic [VALUE_W-1:0] above;

        if (i == 0)
        begin : g_first
            assign below = '0;
        end
        else
        begin : g_mid_lo
            assign below = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign above = '0;
        end
        else
        begin : g_mid_hi
            assign above = cell_data[i+1];
        end

        ole_cell u_cell (
            .clk        (clk),
            .cell_index (IDX_W'(i)),
            .cmd        (cmd),
            .below_data (below),
            .above_data (above),
            .data       (cell_data[i]),
            .match      (match_vec[i]),
            .rd_data    (cell_rd[i])
        );
    end

    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_bus = rd_bus | cell_rd[i];
        end
    end

    ole_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .value        (value),
        .position     (position),
        .eff_cap      (eff_cap),
        .match_vec    (match_vec),
        .rd_bus       (rd_bus),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .read_value   (read_value),
        .found_index  (found_index),
        .entry_count  (entry_count),
        .status       (status)
    );

    // an accepted transfer keeps the input side busy for the compare step
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input not held off after transfer");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_FULL) |-> entry_count >= eff_cap)
        else $error("full reported below capacity");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_EMPTY) |-> entry_count == '0)
        else $error("empty reported with entries present");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> entry_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

endmodule
